### src/crc16_frame_deframer_top_defines.svh
// assertion macros for the crc16 frame deframer
// used at the end of the top level, needs a clk and rst in scope
`ifndef CRC16_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define CRC16_FRAME_DEFRAMER_TOP_DEFINES_SVH

// same-cycle implication
`define CRCFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CRCFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/crcfd_pkg.sv
// shared types, constants and the crc byte update for the frame deframer
// no dependencies
package crcfd_pkg;

  localparam int MAX_PAYLOAD    = 64;
  localparam int FRAME_OVERHEAD = 10;
  localparam int WINDOW_DEPTH   = FRAME_OVERHEAD + MAX_PAYLOAD;
  localparam int MEM_AW         = 7;
  localparam int MEM_DEPTH      = 1 << MEM_AW;
  localparam int LEN_W          = 7;
  localparam int QUEUE_AW       = 2;
  localparam int QUEUE_DEPTH    = 1 << QUEUE_AW;

  localparam logic [7:0]  SOF_BYTE0 = 8'hA5;
  localparam logic [7:0]  SOF_BYTE1 = 8'h5A;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [7:0]  VERSION_RESET = 8'h01;

  // offsets inside a frame
  localparam logic [MEM_AW-1:0] OFS_VERSION = MEM_AW'(2);
  localparam logic [MEM_AW-1:0] OFS_PAYLOAD = MEM_AW'(8);
  localparam logic [MEM_AW-1:0] OFS_LAST_HDR = MEM_AW'(7);
  localparam logic [MEM_AW-1:0] OVERHEAD_W  = MEM_AW'(FRAME_OVERHEAD);
  localparam logic [MEM_AW-1:0] DEPTH_W     = MEM_AW'(WINDOW_DEPTH);
  localparam logic [LEN_W-1:0]  MAX_LEN_W   = LEN_W'(MAX_PAYLOAD);

  typedef struct packed {
    logic [15:0]      seq;
    logic [7:0]       ftype;
    logic [LEN_W-1:0] len;
    logic [7:0]       data;
    logic             has_data;
    logic             last;
  } result_t;

  typedef struct packed {
    logic              busy;
    logic [MEM_AW-1:0] fill;
  } front_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_HDR_RD,
    S_HDR_DAT,
    S_EVAL,
    S_CRC_RD,
    S_CRC_DAT,
    S_CMP,
    S_EMIT_RD,
    S_EMIT_DAT
  } scan_state_t;

  // msb-first ccitt update over one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] din);
    logic [15:0] c;
    c = crc_in ^ {din, 8'h00};
    for (int b = 0; b < 8; b++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

### src/crc16_frame_deframer_top.sv
// after each accepted byte the scanner checks the fill; in_stall holds input while it is not idle
// once ten bytes wait it runs a header scan, a crc pass over the frame bytes and then emission
// of one result per payload byte (one for an empty payload), all through the one memory read port
// rescans after a bad candidate repeat the header scan, one dropped byte each
// reset (rst, synchronous) empties window and queue and sets the version to 1
// no clearing pass: only written window bytes are ever read
module crc16_frame_deframer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        cfg_write_en,
  input  logic [7:0]  cfg_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] frame_seq,
  output logic [7:0]  frame_type,
  output logic [crcfd_pkg::LEN_W-1:0] payload_length,
  output logic [7:0]  data_byte,
  output logic        has_data,
  output logic        last_of_frame
);
  import crcfd_pkg::*;
  `include "crc16_frame_deframer_top_defines.svh"

  result_t       push_data, pop_data;
  logic          q_push, q_pop, q_full, q_empty;
  front_status_t status;

  crcfd_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_byte,
    .cfg_write_en, .cfg_write_data,
    .q_full, .q_push, .q_data(push_data), .status
  );

  crcfd_queue u_queue (
    .clk, .rst, .push(q_push), .push_data, .pop(q_pop),
    .pop_data, .full(q_full), .empty(q_empty)
  );

  crcfd_back u_back (
    .clk, .rst, .q_empty, .q_data(pop_data), .q_pop,
    .out_valid, .out_stall, .frame_seq, .frame_type, .payload_length,
    .data_byte, .has_data, .last_of_frame
  );

  `CRCFD_ASSERT_NOW(a_no_overflow, q_push, !q_full, "push into full queue")
  `CRCFD_ASSERT_NOW(a_no_underflow, q_pop, !q_empty, "pop from empty queue")
  `CRCFD_ASSERT_NOW(a_push_busy, q_push, status.busy, "result pushed while scanner idle")
  `CRCFD_ASSERT_NOW(a_fill_bound, 1'b1, status.fill <= DEPTH_W, "window over capacity")

endmodule

### src/crcfd_front.sv
// front: byte window memory, frame scanner with serial crc check
// depends on crcfd_pkg
module crcfd_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_byte,
  input  logic                   cfg_write_en,
  input  logic [7:0]             cfg_write_data,
  input  logic                   q_full,
  output logic                   q_push,
  output crcfd_pkg::result_t     q_data,
  output crcfd_pkg::front_status_t status
);
  import crcfd_pkg::*;

  scan_state_t state, state_next;

  logic [7:0]        mem [MEM_DEPTH];
  logic [7:0]        rd_data;
  logic [MEM_AW-1:0] head, head_next;
  logic [MEM_AW-1:0] fill, fill_next;
  logic [MEM_AW-1:0] idx, idx_next;
  logic [7:0]        hdr [8];
  logic [15:0]       crc, crc_next;
  logic [7:0]        rx_lo, rx_hi;
  logic [7:0]        expected_version;

  logic              accept;
  logic              hdr_bad;
  logic [LEN_W-1:0]  len;
  logic [MEM_AW-1:0] total;
  logic [MEM_AW-1:0] crc_end;
  logic [MEM_AW-1:0] last_data;

  assign accept    = in_valid && !in_stall;
  assign len       = hdr[3][LEN_W-1:0];
  assign total     = OVERHEAD_W + MEM_AW'(len);
  assign crc_end   = OFS_PAYLOAD + MEM_AW'(len);
  assign last_data = OFS_LAST_HDR + MEM_AW'(len);
  assign hdr_bad   = (hdr[0] != SOF_BYTE0) || (hdr[1] != SOF_BYTE1) ||
                     (hdr[2] != expected_version) || (hdr[4] != 8'h00) ||
                     (hdr[3] > {1'b0, MAX_LEN_W});

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[head + fill] <= in_byte;
    end
    rd_data <= mem[head + idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= VERSION_RESET;
    end else if (cfg_write_en) begin
      expected_version <= cfg_write_data;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (accept) state_next = S_CHECK;
      S_CHECK:   state_next = (fill < OVERHEAD_W) ? S_IDLE : S_HDR_RD;
      S_HDR_RD:  state_next = S_HDR_DAT;
      S_HDR_DAT: state_next = (idx == OFS_LAST_HDR) ? S_EVAL : S_HDR_RD;
      S_EVAL: begin
        if (hdr_bad) state_next = S_CHECK;
        else if (fill < total) state_next = S_IDLE;
        else state_next = S_CRC_RD;
      end
      S_CRC_RD:  state_next = S_CRC_DAT;
      S_CRC_DAT: state_next = (idx == crc_end + MEM_AW'(1)) ? S_CMP : S_CRC_RD;
      S_CMP:     state_next = (crc == {rx_hi, rx_lo}) ? S_EMIT_RD : S_CHECK;
      S_EMIT_RD: state_next = S_EMIT_DAT;
      S_EMIT_DAT: begin
        if (!q_full) begin
          state_next = ((len == '0) || (idx == last_data)) ? S_IDLE : S_EMIT_RD;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_next = head;
    fill_next = fill;
    idx_next  = idx;
    crc_next  = crc;
    in_stall  = (state != S_IDLE);
    q_push    = 1'b0;
    q_data.seq      = {hdr[6], hdr[5]};
    q_data.ftype    = hdr[7];
    q_data.len      = len;
    q_data.data     = (len == '0) ? 8'h00 : rd_data;
    q_data.has_data = (len != '0);
    q_data.last     = (len == '0) || (idx == last_data);
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (fill == DEPTH_W) begin
            head_next = head + MEM_AW'(1);
          end else begin
            fill_next = fill + MEM_AW'(1);
          end
        end
      end
      S_CHECK: idx_next = '0;
      S_HDR_DAT: idx_next = idx + MEM_AW'(1);
      S_EVAL: begin
        if (hdr_bad) begin
          head_next = head + MEM_AW'(1);
          fill_next = fill - MEM_AW'(1);
        end else begin
          idx_next = OFS_VERSION;
          crc_next = CRC_INIT;
        end
      end
      S_CRC_DAT: begin
        idx_next = idx + MEM_AW'(1);
        if (idx < crc_end) crc_next = crc_byte(crc, rd_data);
      end
      S_CMP: begin
        idx_next = OFS_PAYLOAD;
        if (crc != {rx_hi, rx_lo}) begin
          head_next = head + MEM_AW'(1);
          fill_next = fill - MEM_AW'(1);
        end
      end
      S_EMIT_DAT: begin
        if (!q_full) begin
          q_push   = 1'b1;
          idx_next = idx + MEM_AW'(1);
          if ((len == '0) || (idx == last_data)) begin
            head_next = head + total;
            fill_next = fill - total;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      fill  <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    crc <= crc_next;
    if (state == S_HDR_DAT) hdr[idx[2:0]] <= rd_data;
    if (state == S_CRC_DAT && idx == crc_end) rx_lo <= rd_data;
    if (state == S_CRC_DAT && idx == crc_end + MEM_AW'(1)) rx_hi <= rd_data;
  end

  assign status.busy = (state != S_IDLE);
  assign status.fill = fill;

endmodule

### src/crcfd_queue.sv
// short result queue between scanner and output stage
// depends on crcfd_pkg
module crcfd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  crcfd_pkg::result_t push_data,
  input  logic               pop,
  output crcfd_pkg::result_t pop_data,
  output logic               full,
  output logic               empty
);
  import crcfd_pkg::*;

  result_t               slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]     count;

  assign full     = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + QUEUE_AW'(1);
      if (pop && !empty) rd_ptr <= rd_ptr + QUEUE_AW'(1);
      count <= count + (QUEUE_AW+1)'(push && !full) - (QUEUE_AW+1)'(pop && !empty);
    end
  end

endmodule

### src/crcfd_back.sv
// back: output register that drains the result queue
// depends on crcfd_pkg
module crcfd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  crcfd_pkg::result_t q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        frame_seq,
  output logic [7:0]         frame_type,
  output logic [crcfd_pkg::LEN_W-1:0] payload_length,
  output logic [7:0]         data_byte,
  output logic               has_data,
  output logic               last_of_frame
);
  import crcfd_pkg::*;

  result_t held;

  assign q_pop = !q_empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= q_pop || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) held <= q_data;
  end

  assign frame_seq      = held.seq;
  assign frame_type     = held.ftype;
  assign payload_length = held.len;
  assign data_byte      = held.data;
  assign has_data       = held.has_data;
  assign last_of_frame  = held.last;

endmodule
